>>> sv/sbg_pkg.sv
// Shared constants for the spatial bin grid index block.
`default_nettype none
package sbg_pkg;

  localparam int COORD_W = 24;
  localparam int DIV_W   = 25;
  localparam int OIDX_W  = 8;
  localparam int RL_W    = 6;

  localparam int CAP_MIN      = 10;
  localparam int CAP_SCALE    = 100;
  localparam int RESULT_LIMIT = 32;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [COORD_W-1:0] BIN_SIZE_RST = 24'd4096;

endpackage
`default_nettype wire

>>> sv/sbg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module sbg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sbg_pkg::DIV_W-1:0]   dividend_i,
  input  logic [sbg_pkg::COORD_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [sbg_pkg::DIV_W-1:0]   quot_o
);
  import sbg_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]   rem_q, rem_d, quo_q, quo_d, rem_sh;
  logic [COORD_W-1:0] dvs_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q, ge;

  always_comb begin
    rem_sh = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
    quo_d  = {quo_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= CW'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> sv/sbg_ram.sv
// Simple dual-port synchronous RAM, registered read.
`default_nettype none
module sbg_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                         wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/spatial_bin_grid_index.sv
// Top level of the spatial bin grid index: command sequencer and memories.
// Load (cmd 0) stores a source and answers with its index, or with status full when
// the source memory is full. Build (cmd 1) scans the sources for the bounding box,
// runs three serial divisions to size the grid and bin capacity, clears the fill
// counts (one bin per cycle), then inserts every source: a source read, one division
// pair per small source, and per bin write a fill count read, then the entry and
// count write, with a step per neighbor bin to form its index; a large source goes
// into every bin. A query (cmd 2) rebuilds a stale table first, then takes a setup
// step, two divisions and a bin lookup, and returns the bin's source indices one
// by one, each as an entry read and then an output write.
// One item is processed at a time; results leave through an output register.
`default_nettype none
module spatial_bin_grid_index #(
  parameter int MAX_SOURCES   = 256,
  parameter int MAX_BINS      = 1024,
  parameter int BIN_CAPACITY  = 32,
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbg_pkg::COORD_W-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [3*sbg_pkg::COORD_W-1:0] s_axis_tdata,  // pos_x, pos_y, extent
  input  logic [1:0]                    s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sbg_pkg::OIDX_W-1:0]    m_axis_tdata,  // source_index
  output logic [1:0]                    m_axis_tuser,  // status
  output logic                          m_axis_tlast
);
  import sbg_pkg::*;

  localparam int SRC_W = $clog2(MAX_SOURCES + 1);
  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int KW1   = $clog2(MAX_BINS + 1);
  localparam int KW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int FW    = $clog2(BIN_CAPACITY + 1);
  localparam int TW1   = $clog2(TABLE_ENTRIES + 1);
  localparam int TW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SW    = 3 * COORD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP, S_BB_RD, S_BB_UP, S_SPAN, S_DIVX, S_DIVY, S_CHK, S_CHK2,
    S_DIVC, S_CAP, S_CAP2, S_CLR, S_SRC_RD, S_SRC_CHK, S_IX, S_IY, S_NB,
    S_PRD, S_PWR, S_NEXT, S_DONE, S_QSET, S_QX, S_QY, S_QK, S_QRD, S_QFILL, S_QERD,
    S_QEM
  } state_e;

  state_e state_q;

  logic [COORD_W-1:0]        bs_q, edge_len;
  logic [SRC_W-1:0]          cnt_q, j_q;
  logic                      built_q, qry_q;
  logic signed [COORD_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, gmin_x_q, gmin_y_q;
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic [DIV_W-1:0]          colw_q, roww_q, capw_q;
  logic [2*KW1-1:0]          nnw_q;
  logic [KW1+FW-1:0]         tcw_q;
  logic [KW1-1:0]            cols_q, rows_q, nn_q, k_q, ix_q, iy_q;
  logic [FW-1:0]             cap_q;
  logic [1:0]                dx_q, dy_q;
  logic                      sweep_q, negx_q, negy_q;
  logic [TW1-1:0]            kc_q;
  logic [TW-1:0]             slot_q;
  logic [RL_W-1:0]           n_q, m_q;
  logic [OIDX_W-1:0]         rs_idx_q;
  logic [1:0]                rs_st_q;

  logic                      out_v_q, out_last_q, out_free;
  logic [OIDX_W-1:0]         out_idx_q;
  logic [1:0]                out_st_q;

  logic                      div_start_q, div_done;
  logic [DIV_W-1:0]          div_a_q, div_q;
  logic [COORD_W-1:0]        div_b_q;

  logic                      src_we, fill_we, ent_we;
  logic [SW-1:0]             src_rd;
  logic [FW-1:0]             fill_rd, fill_wd;
  logic [OIDX_W-1:0]         ent_rd;
  logic [TW-1:0]             ent_wa;

  logic signed [COORD_W-1:0] sx, sy, se;
  logic signed [COORD_W+3:0] ext10;
  logic signed [DIV_W-1:0]   dqx, dqy;
  logic [DIV_W-1:0]          magx, magy;
  logic signed [KW1+1:0]     cx, cy;
  logic                      nb_ok, nb_last, accept;
  logic [2*KW1-1:0]          nb_prod;

  assign edge_len = (bs_q == '0) ? COORD_W'(1) : bs_q;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_v_q || m_axis_tready;

  assign sx    = src_rd[COORD_W-1:0];
  assign sy    = src_rd[2*COORD_W-1:COORD_W];
  assign se    = src_rd[SW-1:2*COORD_W];
  assign ext10 = ($signed({{4{se[COORD_W-1]}}, se}) <<< 3)
               + ($signed({{4{se[COORD_W-1]}}, se}) <<< 1);

  assign dqx  = $signed({qx_q[COORD_W-1], qx_q}) - $signed({gmin_x_q[COORD_W-1], gmin_x_q});
  assign dqy  = $signed({qy_q[COORD_W-1], qy_q}) - $signed({gmin_y_q[COORD_W-1], gmin_y_q});
  assign magx = dqx[DIV_W-1] ? DIV_W'(-dqx) : DIV_W'(dqx);
  assign magy = dqy[DIV_W-1] ? DIV_W'(-dqy) : DIV_W'(dqy);

  assign cx      = $signed({2'b00, ix_q}) + $signed({{KW1{1'b0}}, dx_q}) - 1;
  assign cy      = $signed({2'b00, iy_q}) + $signed({{KW1{1'b0}}, dy_q}) - 1;
  assign nb_ok   = !cx[KW1+1] && (cx[KW1-1:0] < cols_q) && !cx[KW1]
                && !cy[KW1+1] && (cy[KW1-1:0] < rows_q) && !cy[KW1];
  assign nb_prod = cy[KW1-1:0] * cols_q;
  assign nb_last = (dx_q == 2'd2) && (dy_q == 2'd2);

  assign src_we  = accept && (s_axis_tuser == CMD_LOAD) && (cnt_q < SRC_W'(MAX_SOURCES));
  assign fill_we = (state_q == S_CLR) || ((state_q == S_PWR) && (fill_rd < cap_q));
  assign fill_wd = (state_q == S_CLR) ? '0 : fill_rd + 1'b1;
  assign ent_we  = (state_q == S_PWR) && (fill_rd < cap_q);
  assign ent_wa  = TW'(kc_q + TW1'(fill_rd));

  sbg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  sbg_ram #(.W(SW), .D(MAX_SOURCES)) u_src (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (j_q[IDX_W-1:0]),
    .rdata_o (src_rd)
  );

  sbg_ram #(.W(FW), .D(MAX_BINS)) u_fill (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (k_q[KW-1:0]),
    .wdata_i (fill_wd),
    .raddr_i (k_q[KW-1:0]),
    .rdata_o (fill_rd)
  );

  sbg_ram #(.W(OIDX_W), .D(TABLE_ENTRIES)) u_ent (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_wa),
    .wdata_i (OIDX_W'(j_q)),
    .raddr_i (slot_q),
    .rdata_o (ent_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bs_q        <= BIN_SIZE_RST;
      cnt_q       <= '0;
      j_q         <= '0;
      built_q     <= 1'b0;
      qry_q       <= 1'b0;
      lo_x_q      <= '0;
      hi_x_q      <= '0;
      lo_y_q      <= '0;
      hi_y_q      <= '0;
      gmin_x_q    <= '0;
      gmin_y_q    <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      colw_q      <= '0;
      roww_q      <= '0;
      capw_q      <= '0;
      nnw_q       <= '0;
      tcw_q       <= '0;
      cols_q      <= '0;
      rows_q      <= '0;
      nn_q        <= '0;
      k_q         <= '0;
      ix_q        <= '0;
      iy_q        <= '0;
      cap_q       <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sweep_q     <= 1'b0;
      negx_q      <= 1'b0;
      negy_q      <= 1'b0;
      kc_q        <= '0;
      slot_q      <= '0;
      n_q         <= '0;
      m_q         <= '0;
      rs_idx_q    <= '0;
      rs_st_q     <= ST_OK;
      out_v_q     <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_st_q    <= ST_OK;
      div_start_q <= 1'b0;
      div_a_q     <= '0;
      div_b_q     <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        bs_q <= cfg_wdata_i;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            qry_q <= 1'b0;
            qx_q  <= s_axis_tdata[COORD_W-1:0];
            qy_q  <= s_axis_tdata[2*COORD_W-1:COORD_W];
            priority case (s_axis_tuser)
              CMD_LOAD: begin
                if (cnt_q < SRC_W'(MAX_SOURCES)) begin
                  rs_idx_q <= OIDX_W'(cnt_q);
                  rs_st_q  <= ST_OK;
                  cnt_q    <= cnt_q + 1'b1;
                  built_q  <= 1'b0;
                end else begin
                  rs_idx_q <= '0;
                  rs_st_q  <= ST_FULL;
                end
                state_q <= S_RESP;
              end
              CMD_BUILD, CMD_QUERY: begin
                if ((s_axis_tuser == CMD_QUERY) && built_q) begin
                  state_q <= S_QSET;
                end else begin
                  qry_q   <= (s_axis_tuser == CMD_QUERY);
                  built_q <= 1'b0;
                  j_q     <= '0;
                  lo_x_q  <= '0;
                  hi_x_q  <= '0;
                  lo_y_q  <= '0;
                  hi_y_q  <= '0;
                  state_q <= (cnt_q == '0) ? S_SPAN : S_BB_RD;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_idx_q  <= rs_idx_q;
            out_st_q   <= rs_st_q;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end

        S_BB_RD: state_q <= S_BB_UP;

        S_BB_UP: begin
          if ((j_q == '0) || (sx < lo_x_q)) lo_x_q <= sx;
          if ((j_q == '0) || (sx > hi_x_q)) hi_x_q <= sx;
          if ((j_q == '0) || (sy < lo_y_q)) lo_y_q <= sy;
          if ((j_q == '0) || (sy > hi_y_q)) hi_y_q <= sy;
          if (j_q == cnt_q - 1'b1) begin
            state_q <= S_SPAN;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_BB_RD;
          end
        end

        S_SPAN: begin
          div_a_q     <= DIV_W'($signed({hi_x_q[COORD_W-1], hi_x_q})
                                - $signed({lo_x_q[COORD_W-1], lo_x_q}));
          div_b_q     <= edge_len;
          div_start_q <= 1'b1;
          state_q     <= S_DIVX;
        end

        S_DIVX: begin
          if (div_done) begin
            colw_q      <= div_q + 1'b1;
            div_a_q     <= DIV_W'($signed({hi_y_q[COORD_W-1], hi_y_q})
                                  - $signed({lo_y_q[COORD_W-1], lo_y_q}));
            div_start_q <= 1'b1;
            state_q     <= S_DIVY;
          end
        end

        S_DIVY: begin
          if (div_done) begin
            roww_q  <= div_q + 1'b1;
            state_q <= S_CHK;
          end
        end

        S_CHK: begin
          if ((colw_q > DIV_W'(MAX_BINS)) || (roww_q > DIV_W'(MAX_BINS))) begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_OVF;
            state_q  <= S_RESP;
          end else begin
            cols_q  <= colw_q[KW1-1:0];
            rows_q  <= roww_q[KW1-1:0];
            nnw_q   <= colw_q[KW1-1:0] * roww_q[KW1-1:0];
            state_q <= S_CHK2;
          end
        end

        S_CHK2: begin
          if (nnw_q > (2*KW1)'(MAX_BINS)) begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_OVF;
            state_q  <= S_RESP;
          end else begin
            nn_q        <= nnw_q[KW1-1:0];
            div_a_q     <= DIV_W'(cnt_q) * DIV_W'(CAP_SCALE);
            div_b_q     <= COORD_W'(nnw_q[KW1-1:0]);
            div_start_q <= 1'b1;
            state_q     <= S_DIVC;
          end
        end

        S_DIVC: begin
          if (div_done) begin
            capw_q  <= (div_q < DIV_W'(CAP_MIN)) ? DIV_W'(CAP_MIN) : div_q;
            state_q <= S_CAP;
          end
        end

        S_CAP: begin
          if (capw_q > DIV_W'(BIN_CAPACITY)) begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_OVF;
            state_q  <= S_RESP;
          end else begin
            cap_q   <= capw_q[FW-1:0];
            tcw_q   <= nn_q * capw_q[FW-1:0];
            state_q <= S_CAP2;
          end
        end

        S_CAP2: begin
          if (tcw_q > (KW1+FW)'(TABLE_ENTRIES)) begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_OVF;
            state_q  <= S_RESP;
          end else begin
            gmin_x_q <= lo_x_q;
            gmin_y_q <= lo_y_q;
            k_q      <= '0;
            state_q  <= S_CLR;
          end
        end

        S_CLR: begin
          if (k_q == nn_q - 1'b1) begin
            j_q     <= '0;
            state_q <= (cnt_q == '0) ? S_DONE : S_SRC_RD;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        S_SRC_RD: state_q <= S_SRC_CHK;

        S_SRC_CHK: begin
          if (ext10 > $signed({4'b0000, edge_len})) begin
            sweep_q <= 1'b1;
            k_q     <= '0;
            state_q <= S_PRD;
          end else begin
            sweep_q     <= 1'b0;
            div_a_q     <= DIV_W'($signed({sx[COORD_W-1], sx})
                                  - $signed({lo_x_q[COORD_W-1], lo_x_q}));
            div_b_q     <= edge_len;
            div_start_q <= 1'b1;
            state_q     <= S_IX;
          end
        end

        S_IX: begin
          if (div_done) begin
            ix_q        <= KW1'(div_q);
            div_a_q     <= DIV_W'($signed({sy[COORD_W-1], sy})
                                  - $signed({lo_y_q[COORD_W-1], lo_y_q}));
            div_start_q <= 1'b1;
            state_q     <= S_IY;
          end
        end

        S_IY: begin
          if (div_done) begin
            iy_q    <= KW1'(div_q);
            dx_q    <= '0;
            dy_q    <= '0;
            state_q <= S_NB;
          end
        end

        S_NB: begin
          if (nb_ok) begin
            k_q     <= cx[KW1-1:0] + KW1'(nb_prod);
            state_q <= S_PRD;
          end else if (nb_last) begin
            state_q <= S_NEXT;
          end else begin
            if (dy_q == 2'd2) begin
              dy_q <= '0;
              dx_q <= dx_q + 1'b1;
            end else begin
              dy_q <= dy_q + 1'b1;
            end
          end
        end

        S_PRD: begin
          kc_q    <= TW1'(k_q * cap_q);
          state_q <= S_PWR;
        end

        S_PWR: begin
          if (fill_rd >= cap_q) begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_OVF;
            state_q  <= S_RESP;
          end else if (sweep_q) begin
            if (k_q == nn_q - 1'b1) begin
              state_q <= S_NEXT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_PRD;
            end
          end else if (nb_last) begin
            state_q <= S_NEXT;
          end else begin
            if (dy_q == 2'd2) begin
              dy_q <= '0;
              dx_q <= dx_q + 1'b1;
            end else begin
              dy_q <= dy_q + 1'b1;
            end
            state_q <= S_NB;
          end
        end

        S_NEXT: begin
          if (j_q == cnt_q - 1'b1) begin
            state_q <= S_DONE;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SRC_RD;
          end
        end

        S_DONE: begin
          built_q <= 1'b1;
          if (qry_q) begin
            state_q <= S_QSET;
          end else begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_OK;
            state_q  <= S_RESP;
          end
        end

        S_QSET: begin
          div_a_q     <= magx;
          div_b_q     <= edge_len;
          negx_q      <= dqx[DIV_W-1];
          div_start_q <= 1'b1;
          state_q     <= S_QX;
        end

        S_QX: begin
          if (div_done) begin
            if ((negx_q && (div_q != '0)) || (div_q >= DIV_W'(cols_q))) begin
              rs_idx_q <= '0;
              rs_st_q  <= ST_EMPTY;
              state_q  <= S_RESP;
            end else begin
              ix_q        <= KW1'(div_q);
              div_a_q     <= magy;
              negy_q      <= dqy[DIV_W-1];
              div_start_q <= 1'b1;
              state_q     <= S_QY;
            end
          end
        end

        S_QY: begin
          if (div_done) begin
            if ((negy_q && (div_q != '0)) || (div_q >= DIV_W'(rows_q))) begin
              rs_idx_q <= '0;
              rs_st_q  <= ST_EMPTY;
              state_q  <= S_RESP;
            end else begin
              iy_q    <= KW1'(div_q);
              state_q <= S_QK;
            end
          end
        end

        S_QK: begin
          k_q     <= ix_q + KW1'(iy_q * cols_q);
          state_q <= S_QRD;
        end

        S_QRD: begin
          kc_q    <= TW1'(k_q * cap_q);
          state_q <= S_QFILL;
        end

        S_QFILL: begin
          if (fill_rd == '0) begin
            rs_idx_q <= '0;
            rs_st_q  <= ST_EMPTY;
            state_q  <= S_RESP;
          end else begin
            n_q     <= (int'(fill_rd) > RESULT_LIMIT) ? RL_W'(RESULT_LIMIT) : RL_W'(fill_rd);
            m_q     <= '0;
            slot_q  <= TW'(kc_q);
            state_q <= S_QERD;
          end
        end

        S_QERD: state_q <= S_QEM;

        S_QEM: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_idx_q  <= ent_rd;
            out_st_q   <= ST_OK;
            out_last_q <= (m_q + 1'b1 == n_q);
            if (m_q + 1'b1 == n_q) begin
              state_q <= S_IDLE;
            end else begin
              m_q     <= m_q + 1'b1;
              slot_q  <= slot_q + 1'b1;
              state_q <= S_QERD;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_idx_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
